>>> hw/rtl/i2cme_pkg.sv
// Shared types and constants for the I2C master byte engine.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package i2cme_pkg;

    // configuration register indexes
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 16;
    localparam logic [CfgIdxW-1:0] CFG_SS_HOLD   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_BIT_HALF  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SHORT_WT  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_RETRY_LIM = 2'd3;

    // configuration reset values
    localparam logic [15:0] SS_HOLD_RST   = 16'd4;
    localparam logic [15:0] BIT_HALF_RST  = 16'd2;
    localparam logic [15:0] SHORT_WT_RST  = 16'd1;
    localparam logic [7:0]  RETRY_LIM_RST = 8'd250;

    // command codes as they arrive in the mode field
    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_WAIT  = 3'd4
    } cmd_t;

    // engine phases
    typedef enum logic [14:0] {
        PH_IDLE  = 15'b000000000000001,
        PH_ST_A  = 15'b000000000000010,
        PH_ST_B  = 15'b000000000000100,
        PH_SP_A  = 15'b000000000001000,
        PH_SP_B  = 15'b000000000010000,
        PH_WR_LO = 15'b000000000100000,
        PH_WR_HI = 15'b000000001000000,
        PH_WR_TL = 15'b000000010000000,
        PH_RD_LO = 15'b000000100000000,
        PH_RD_HI = 15'b000001000000000,
        PH_AK_LO = 15'b000010000000000,
        PH_AK_HI = 15'b000100000000000,
        PH_WA_A  = 15'b001000000000000,
        PH_WA_B  = 15'b010000000000000,
        PH_POLL  = 15'b100000000000000
    } phase_t;

    // one input item (one tick)
    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } tick_t;

    // one result item
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_fail;
    } res_t;

    // classified tick handed from front to back
    typedef struct packed {
        logic       go;
        cmd_t       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } work_t;

    // live configuration
    typedef struct packed {
        logic [15:0] ss_hold;
        logic [15:0] bit_half;
        logic [15:0] short_wait;
        logic [7:0]  retry_limit;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/i2cme_front.sv
// Front end: accepts ticks, decodes the command and queues them two deep.
// Depends on i2cme_pkg.
`default_nettype none

module i2cme_front
    import i2cme_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  tick_valid,
    output logic       tick_stall,
    input  wire tick_t tick,
    output logic       work_valid,
    output work_t      work,
    input  wire logic  work_pop
);

    work_t       q_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        push;
    work_t       decoded;

    // command decode: unknown modes never start anything
    always_comb
    begin
        decoded.tx_byte  = tick.tx_byte;
        decoded.send_ack = tick.send_ack;
        decoded.sda_in   = tick.sda_in;
        decoded.go       = tick.cmd_valid;
        decoded.cmd      = CMD_START;
        unique case (tick.mode)
            CMD_START: decoded.cmd = CMD_START;
            CMD_STOP:  decoded.cmd = CMD_STOP;
            CMD_WRITE: decoded.cmd = CMD_WRITE;
            CMD_READ:  decoded.cmd = CMD_READ;
            CMD_WAIT:  decoded.cmd = CMD_WAIT;
            default:   decoded.go  = 1'b0;
        endcase
    end

    // queue control
    assign tick_stall = (cnt_reg == 2'd2);
    assign push       = tick_valid && !tick_stall;
    assign work_valid = (cnt_reg != 2'd0);
    assign work       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ work_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, work_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2cme_back.sv
// Back end: the bit engine, into an output register; one queued tick per cycle
// unless a stalled result is held. Depends on i2cme_pkg.
`default_nettype none

module i2cme_back
    import i2cme_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  work_valid,
    input  wire work_t work,
    output logic       work_pop,
    output logic       res_valid,
    input  wire logic  res_stall,
    output res_t       res
);

    phase_t      phase_reg,   phase_next;
    cmd_t        cmd_reg,     cmd_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [15:0] wait_reg,    wait_next;
    logic [7:0]  shreg_reg,   shreg_next;
    logic [7:0]  retry_reg,   retry_next;
    logic        ackc_reg,    ackc_next;
    logic        scl_reg,     scl_next;
    logic        sda_reg,     sda_next;
    logic [7:0]  rx_reg,      rx_next;
    logic        fail_reg,    fail_next;
    logic        done;
    logic        out_valid_reg, out_valid_next;
    res_t        out_reg,     out_next;

    // hold count of zero acts as one tick
    function automatic logic [15:0] hold_of(input logic [15:0] n);
        return (n == 16'd0) ? 16'd0 : n - 16'd1;
    endfunction

    assign work_pop = work_valid && (!out_valid_reg || !res_stall);

    // engine step
    always_comb
    begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        bit_cnt_next = bit_cnt_reg;
        wait_next    = wait_reg;
        shreg_next   = shreg_reg;
        retry_next   = retry_reg;
        ackc_next    = ackc_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        rx_next      = rx_reg;
        fail_next    = fail_reg;
        done         = 1'b0;
        if (phase_reg == PH_IDLE)
        begin
            if (work.go)
            begin
                cmd_next     = work.cmd;
                bit_cnt_next = 3'd0;
                unique case (work.cmd)
                    CMD_START:
                    begin
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        phase_next = PH_ST_A;
                        wait_next  = hold_of(cfg.ss_hold);
                    end
                    CMD_STOP:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = PH_SP_A;
                        wait_next  = hold_of(cfg.ss_hold);
                    end
                    CMD_WRITE:
                    begin
                        scl_next   = 1'b0;
                        sda_next   = work.tx_byte[7];
                        shreg_next = {work.tx_byte[6:0], 1'b0};
                        phase_next = PH_WR_LO;
                        wait_next  = hold_of(cfg.bit_half);
                    end
                    CMD_READ:
                    begin
                        shreg_next = 8'd0;
                        ackc_next  = work.send_ack;
                        scl_next   = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = PH_RD_LO;
                        wait_next  = hold_of(cfg.bit_half);
                    end
                    default:
                    begin
                        retry_next = 8'd0;
                        fail_next  = 1'b0;
                        sda_next   = 1'b1;
                        phase_next = PH_WA_A;
                        wait_next  = hold_of(cfg.short_wait);
                    end
                endcase
            end
        end
        else if (wait_reg != 16'd0)
        begin
            wait_next = wait_reg - 16'd1;
        end
        else
        begin
            unique case (phase_reg)
                PH_ST_A:
                begin
                    sda_next   = 1'b0;
                    phase_next = PH_ST_B;
                    wait_next  = hold_of(cfg.ss_hold);
                end
                PH_ST_B:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                PH_SP_A:
                begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_SP_B;
                    wait_next  = hold_of(cfg.ss_hold);
                end
                PH_SP_B:
                begin
                    // a stop issued by an acknowledge timeout flags the failure
                    if (cmd_reg == CMD_WAIT)
                    begin
                        fail_next = 1'b1;
                    end
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                PH_WR_LO:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_WR_HI;
                    wait_next  = hold_of(cfg.bit_half);
                end
                PH_WR_HI:
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_WR_TL;
                    wait_next  = hold_of(cfg.bit_half);
                end
                PH_WR_TL:
                begin
                    if (bit_cnt_reg != 3'd7)
                    begin
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        sda_next     = shreg_reg[7];
                        shreg_next   = {shreg_reg[6:0], 1'b0};
                        phase_next   = PH_WR_LO;
                        wait_next    = hold_of(cfg.bit_half);
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                PH_RD_LO:
                begin
                    scl_next   = 1'b1;
                    shreg_next = {shreg_reg[6:0], work.sda_in};
                    phase_next = PH_RD_HI;
                    wait_next  = hold_of(cfg.short_wait);
                end
                PH_RD_HI:
                begin
                    scl_next = 1'b0;
                    if (bit_cnt_reg != 3'd7)
                    begin
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        phase_next   = PH_RD_LO;
                        wait_next    = hold_of(cfg.bit_half);
                    end
                    else
                    begin
                        sda_next   = !ackc_reg;
                        phase_next = PH_AK_LO;
                        wait_next  = hold_of(cfg.bit_half);
                    end
                end
                PH_AK_LO:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_AK_HI;
                    wait_next  = hold_of(cfg.bit_half);
                end
                PH_AK_HI:
                begin
                    scl_next   = 1'b0;
                    rx_next    = shreg_reg;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                PH_WA_A:
                begin
                    scl_next   = 1'b1;
                    phase_next = PH_WA_B;
                    wait_next  = hold_of(cfg.short_wait);
                end
                PH_WA_B:
                begin
                    phase_next = PH_POLL;
                    wait_next  = 16'd0;
                end
                PH_POLL:
                begin
                    if (!work.sda_in)
                    begin
                        scl_next   = 1'b0;
                        fail_next  = 1'b0;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    else if (retry_reg >= cfg.retry_limit)
                    begin
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = PH_SP_A;
                        wait_next  = hold_of(cfg.ss_hold);
                    end
                    else
                    begin
                        retry_next = retry_reg + 8'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // result for this tick
    always_comb
    begin
        out_next.scl_out  = scl_next;
        out_next.sda_out  = sda_next;
        out_next.busy_res = (phase_next != PH_IDLE);
        out_next.done_res = done;
        out_next.rx_byte  = rx_next;
        out_next.ack_fail = fail_next;
        out_valid_next    = work_pop || (out_valid_reg && res_stall);
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // engine state, advanced only when a tick is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cmd_reg       <= CMD_START;
            bit_cnt_reg   <= 3'd0;
            wait_reg      <= 16'd0;
            shreg_reg     <= 8'd0;
            retry_reg     <= 8'd0;
            ackc_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            rx_reg        <= 8'd0;
            fail_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (work_pop)
            begin
                phase_reg   <= phase_next;
                cmd_reg     <= cmd_next;
                bit_cnt_reg <= bit_cnt_next;
                wait_reg    <= wait_next;
                shreg_reg   <= shreg_next;
                retry_reg   <= retry_next;
                ackc_reg    <= ackc_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                rx_reg      <= rx_next;
                fail_reg    <= fail_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (work_pop)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2c_master_byte_engine.sv
// An accepted tick is registered in the queue, then in the output register.
// Throughput: one tick per cycle; the engine consumes one queued tick each cycle
// the output register is free or being taken, and a two-entry queue absorbs stalls.
// Reset: asynchronous, active low; engine idle, both lines released high,
// flags and received byte cleared, configuration back to its defaults.
// Top level: configuration registers, front decode queue and back bit engine.
`default_nettype none

module i2c_master_byte_engine
    import i2cme_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                tick_valid,
    output logic                     tick_stall,
    input  wire tick_t               tick,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output res_t                     res,
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  work_valid;
    work_t work;
    logic  work_pop;

    // configuration write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SS_HOLD:   cfg_next.ss_hold     = cfg_data;
                CFG_BIT_HALF:  cfg_next.bit_half    = cfg_data;
                CFG_SHORT_WT:  cfg_next.short_wait  = cfg_data;
                CFG_RETRY_LIM: cfg_next.retry_limit = cfg_data[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ss_hold     <= SS_HOLD_RST;
            cfg_reg.bit_half    <= BIT_HALF_RST;
            cfg_reg.short_wait  <= SHORT_WT_RST;
            cfg_reg.retry_limit <= RETRY_LIM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // tick intake and decode
    i2cme_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick       (tick),
        .work_valid (work_valid),
        .work       (work),
        .work_pop   (work_pop)
    );

    // bit engine and result register
    i2cme_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .work_valid (work_valid),
        .work       (work),
        .work_pop   (work_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

`default_nettype wire

>>> hw/rtl/i2cme_checker.sv
// Port-level checks for the I2C master byte engine, bound to the top level.
// Depends on i2cme_pkg and i2c_master_byte_engine.
`default_nettype none

module i2cme_checker
    import i2cme_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                tick_valid,
    input wire logic                tick_stall,
    input wire logic                res_valid,
    input wire logic                res_stall,
    input wire res_t                res
);

    // a completing tick never reports busy
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.done_res |-> !res.busy_res)
        else $error("done reported while busy");

    // an accepted tick leads to a result waiting at the output
    a_tick_to_res: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && !tick_stall |-> ##2 res_valid)
        else $error("no result after accepted tick");

    // intake only backs up when the result side is holding an item
    a_stall_needs_res: assert property (@(posedge clk) disable iff (!rst_n)
        tick_stall |-> res_valid)
        else $error("intake stalled with empty output");

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

endmodule

bind i2c_master_byte_engine i2cme_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the I2C master byte engine: drives one tick item per
// handshake, predicts every result item and compares them field by field.
// Depends on i2cme_pkg and the i2c_master_byte_engine RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import i2cme_pkg::*;

    typedef enum {SDA_LOW, SDA_HIGH, SDA_RAND} sda_pol_t;

    // bit engine prediction and the queue of line levels still owed by the block
    class engine_checker;
        logic [15:0] ss_hold;
        logic [15:0] bit_half;
        logic [15:0] short_wait;
        logic [7:0]  retry_limit;
        phase_t      ph;
        logic [2:0]  active_cmd;
        logic [3:0]  bit_cnt;
        logic [15:0] wait_cnt;
        logic [7:0]  shifter;
        logic [7:0]  retries;
        logic        ack_sel;
        logic        scl;
        logic        sda;
        logic [7:0]  rx_data;
        logic        fail;
        res_t        expected_lines[$];
        int          errors;

        function new();
            ss_hold = SS_HOLD_RST;
            bit_half = BIT_HALF_RST;
            short_wait = SHORT_WT_RST;
            retry_limit = RETRY_LIM_RST;
            ph = PH_IDLE;
            active_cmd = '0;
            bit_cnt = '0;
            wait_cnt = '0;
            shifter = '0;
            retries = '0;
            ack_sel = 1'b0;
            scl = 1'b1;
            sda = 1'b1;
            rx_data = '0;
            fail = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                CFG_SS_HOLD:   ss_hold = data;
                CFG_BIT_HALF:  bit_half = data;
                CFG_SHORT_WT:  short_wait = data;
                CFG_RETRY_LIM: retry_limit = data[7:0];
                default: ;
            endcase
        endfunction

        // a segment of hold n lasts n ticks, zero behaves as one
        function void enter(phase_t nxt, logic [15:0] n);
            ph = nxt;
            wait_cnt = (n == 16'd0) ? 16'd0 : n - 16'd1;
        endfunction

        function void shift_out();
            sda = shifter[7];
            shifter = shifter << 1;
        endfunction

        // advance the engine by one accepted tick and queue the resulting levels
        function void note_tick(tick_t t);
            logic done;
            res_t r;
            done = 1'b0;
            if (ph == PH_IDLE)
            begin
                // only an idle engine takes a command, modes above wait are dropped
                if (t.cmd_valid && t.mode <= CMD_WAIT)
                begin
                    active_cmd = t.mode;
                    bit_cnt = 4'd0;
                    case (t.mode)
                        CMD_START:
                        begin
                            sda = 1'b1;
                            scl = 1'b1;
                            enter(PH_ST_A, ss_hold);
                        end
                        CMD_STOP:
                        begin
                            scl = 1'b0;
                            sda = 1'b0;
                            enter(PH_SP_A, ss_hold);
                        end
                        CMD_WRITE:
                        begin
                            shifter = t.tx_byte;
                            scl = 1'b0;
                            shift_out();
                            enter(PH_WR_LO, bit_half);
                        end
                        CMD_READ:
                        begin
                            shifter = 8'h00;
                            ack_sel = t.send_ack;
                            scl = 1'b0;
                            sda = 1'b1;
                            enter(PH_RD_LO, bit_half);
                        end
                        default:
                        begin
                            retries = 8'h00;
                            fail = 1'b0;
                            sda = 1'b1;
                            enter(PH_WA_A, short_wait);
                        end
                    endcase
                end
            end
            else if (wait_cnt != 16'd0)
            begin
                wait_cnt--;
            end
            else
            begin
                // segment finished: take the next line action
                case (ph)
                    PH_ST_A:
                    begin
                        sda = 1'b0;
                        enter(PH_ST_B, ss_hold);
                    end
                    PH_ST_B:
                    begin
                        scl = 1'b0;
                        ph = PH_IDLE;
                        done = 1'b1;
                    end
                    PH_SP_A:
                    begin
                        scl = 1'b1;
                        sda = 1'b1;
                        enter(PH_SP_B, ss_hold);
                    end
                    PH_SP_B:
                    begin
                        if (active_cmd == CMD_WAIT)
                            fail = 1'b1;
                        ph = PH_IDLE;
                        done = 1'b1;
                    end
                    PH_WR_LO:
                    begin
                        scl = 1'b1;
                        enter(PH_WR_HI, bit_half);
                    end
                    PH_WR_HI:
                    begin
                        scl = 1'b0;
                        enter(PH_WR_TL, bit_half);
                    end
                    PH_WR_TL:
                    begin
                        if (bit_cnt < 4'd7)
                        begin
                            bit_cnt++;
                            shift_out();
                            enter(PH_WR_LO, bit_half);
                        end
                        else
                        begin
                            ph = PH_IDLE;
                            done = 1'b1;
                        end
                    end
                    PH_RD_LO:
                    begin
                        scl = 1'b1;
                        shifter = {shifter[6:0], t.sda_in};
                        enter(PH_RD_HI, short_wait);
                    end
                    PH_RD_HI:
                    begin
                        scl = 1'b0;
                        if (bit_cnt < 4'd7)
                        begin
                            bit_cnt++;
                            enter(PH_RD_LO, bit_half);
                        end
                        else
                        begin
                            sda = !ack_sel;
                            enter(PH_AK_LO, bit_half);
                        end
                    end
                    PH_AK_LO:
                    begin
                        scl = 1'b1;
                        enter(PH_AK_HI, bit_half);
                    end
                    PH_AK_HI:
                    begin
                        scl = 1'b0;
                        rx_data = shifter;
                        ph = PH_IDLE;
                        done = 1'b1;
                    end
                    PH_WA_A:
                    begin
                        scl = 1'b1;
                        enter(PH_WA_B, short_wait);
                    end
                    PH_WA_B:
                    begin
                        enter(PH_POLL, 16'd1);
                    end
                    PH_POLL:
                    begin
                        // low sample acks, high at the retry limit falls into a stop
                        if (!t.sda_in)
                        begin
                            scl = 1'b0;
                            fail = 1'b0;
                            ph = PH_IDLE;
                            done = 1'b1;
                        end
                        else if (retries >= retry_limit)
                        begin
                            scl = 1'b0;
                            sda = 1'b0;
                            enter(PH_SP_A, ss_hold);
                        end
                        else
                        begin
                            retries++;
                        end
                    end
                    default:
                    begin
                        ph = PH_IDLE;
                    end
                endcase
            end
            r.scl_out = scl;
            r.sda_out = sda;
            r.busy_res = (ph != PH_IDLE);
            r.done_res = done;
            r.rx_byte = rx_data;
            r.ack_fail = fail;
            expected_lines.push_back(r);
        endfunction

        function void compare(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $error("%s: expected %0h, got %0h", field, want, got);
            end
        endfunction

        // compare one accepted result item against the oldest prediction
        function void check_result(res_t got);
            res_t want;
            if (expected_lines.size() == 0)
            begin
                errors++;
                $error("result item with nothing expected: %p", got);
                return;
            end
            want = expected_lines.pop_front();
            compare("scl_out", 8'(want.scl_out), 8'(got.scl_out));
            compare("sda_out", 8'(want.sda_out), 8'(got.sda_out));
            compare("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            compare("done_res", 8'(want.done_res), 8'(got.done_res));
            compare("rx_byte", want.rx_byte, got.rx_byte);
            compare("ack_fail", 8'(want.ack_fail), 8'(got.ack_fail));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                tick_valid;
    logic                tick_stall;
    tick_t               tick;
    logic                res_valid;
    logic                res_stall;
    res_t                res;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    engine_checker chk;
    bit            quiet;
    int            hold_off_left;

    i2c_master_byte_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick       (tick),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 12 ns clock
    always #6 clk = ~clk;

    // result side: random stalls plus one long hold-off counted down here
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                res_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < 15)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                chk.check_result(res);
        end
    end

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        if (quiet || hold_off_left > 0)
            return 0;
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 14) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic tick_t make_tick(logic valid, logic [2:0] mode, logic [7:0] tx,
                                        logic ack, logic sda);
        tick_t t;
        t.cmd_valid = valid;
        t.mode = mode;
        t.tx_byte = tx;
        t.send_ack = ack;
        t.sda_in = sda;
        return t;
    endfunction

    function automatic logic line_sample(sda_pol_t pol);
        case (pol)
            SDA_LOW:  return 1'b0;
            SDA_HIGH: return 1'b1;
            default:  return 1'($urandom);
        endcase
    endfunction

    // offer one tick item after a random gap and record it once taken
    task automatic send_tick(input tick_t t);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            tick_valid <= 1'b0;
        end
        @(negedge clk);
        tick_valid <= 1'b1;
        tick <= t;
        do
        begin
            @(posedge clk);
        end
        while (tick_stall);
        chk.note_tick(t);
    endtask

    // issue a command to the idle engine and keep ticking until it is idle again
    task automatic run_cmd(input logic [2:0] mode, input logic [7:0] tx, input logic ack,
                           input sda_pol_t pol, input bit noise);
        send_tick(make_tick(1'b1, mode, tx, ack, line_sample(pol)));
        while (chk.ph != PH_IDLE)
            send_tick(make_tick(noise, 3'($urandom_range(0, 7)), 8'($urandom),
                                1'($urandom), line_sample(pol)));
    endtask

    // finish the current command, then wait for every owed result
    task automatic settle();
        while (chk.ph != PH_IDLE)
            send_tick(make_tick(1'b0, CMD_START, 8'h00, 1'b0, 1'($urandom)));
        @(negedge clk);
        tick_valid <= 1'b0;
        while (chk.expected_lines.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        chk.write_reg(idx, data);
    endtask

    task automatic set_all(input logic [15:0] ss, input logic [15:0] bh,
                           input logic [15:0] sw, input logic [15:0] rl);
        write_reg(CFG_SS_HOLD, ss);
        write_reg(CFG_BIT_HALF, bh);
        write_reg(CFG_SHORT_WT, sw);
        write_reg(CFG_RETRY_LIM, rl);
    endtask

    // random ticks: commands whenever idle, noise commands and random sda while busy
    task automatic random_run(input int n_ticks);
        tick_t t;
        repeat (n_ticks)
        begin
            t = '0;
            if (chk.ph == PH_IDLE)
            begin
                t.cmd_valid = ($urandom_range(0, 9) < 9);
                t.mode = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                      : 3'($urandom_range(0, 4));
            end
            else
            begin
                t.cmd_valid = ($urandom_range(0, 4) == 0);
                t.mode = 3'($urandom_range(0, 7));
            end
            t.tx_byte = 8'($urandom);
            t.send_ack = 1'($urandom);
            t.sda_in = (chk.ph == PH_POLL) ? ($urandom_range(0, 3) != 0) : 1'($urandom);
            send_tick(t);
        end
    endtask

    // run limit
    initial
    begin
        #40_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // main sequence
    initial
    begin
        chk = new();
        quiet = 1'b0;
        hold_off_left = 0;
        rst_n = 1'b0;
        tick_valid = 1'b0;
        tick = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_SS_HOLD;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed at reset settings: idle tick, unused modes, every command
        send_tick(make_tick(1'b0, CMD_WRITE, 8'hFF, 1'b1, 1'b0));
        for (int m = int'(CMD_WAIT) + 1; m < 8; m++)
            run_cmd(3'(m), 8'h00, 1'b0, SDA_RAND, 1'b0);
        run_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b1);
        run_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_RAND, 1'b1);
        run_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_RAND, 1'b0);
        run_cmd(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 1'b1);
        run_cmd(CMD_READ, 8'hFF, 1'b0, SDA_LOW, 1'b0);
        run_cmd(CMD_READ, 8'($urandom), 1'b1, SDA_RAND, 1'b1);
        // ack on first poll, timeout after the full retry budget, then clear
        run_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_LOW, 1'b0);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_HIGH, 1'b1);
        run_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_RAND, 1'b0);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_LOW, 1'b1);
        run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1);
        settle();

        // zero holds and a zero retry limit
        set_all(16'h0000, 16'h0000, 16'h0000, 16'hFF00);
        run_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b0);
        run_cmd(CMD_WRITE, 8'h5A, 1'b0, SDA_RAND, 1'b1);
        run_cmd(CMD_READ, 8'h00, 1'b0, SDA_RAND, 1'b0);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_LOW, 1'b1);
        run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b0);
        settle();

        // random phases with small timing settings
        for (int p = 0; p < 4; p++)
        begin
            set_all(16'($urandom_range(0, 5)), 16'($urandom_range(0, 3)),
                    16'($urandom_range(0, 3)), {8'($urandom), 8'($urandom_range(0, 6))});
            quiet = (p == 2);
            if (p == 0)
                hold_off_left = 60;
            random_run(75);
            settle();
        end

        // widest retry limit, no idling
        quiet = 1'b1;
        set_all(16'h0001, 16'h0001, 16'h0001, 16'hFFFF);
        run_cmd(CMD_START, 8'h00, 1'b0, SDA_RAND, 1'b1);
        run_cmd(CMD_WAIT, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 1'b1);
        settle();
        quiet = 1'b0;

        if (chk.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/i2cme_pkg.sv
hw/rtl/i2cme_front.sv
hw/rtl/i2cme_back.sv
hw/rtl/i2c_master_byte_engine.sv
hw/rtl/i2cme_checker.sv
tb/tb_top.sv
